[src/tre_pkg.sv]
package tre_pkg;

	localparam int PixW = 8;
	localparam int RowW = 12;
	localparam int ColW = 12;
	localparam int StopW = 13;

	localparam logic [PixW-1:0] ThresholdReset = 8'd128;

	typedef struct packed {
		logic [PixW-1:0] pixel_value;
		logic [RowW-1:0] row_number;
		logic            line_end;
	} pix_t;

	typedef struct packed {
		logic [RowW-1:0]  row;
		logic [ColW-1:0]  first;
		logic [StopW-1:0] stop;
	} run_t;

endpackage

[src/tre_in_stage.sv]
module tre_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  tre_pkg::pix_t in_item,
	input  logic          advance,
	output logic          valid_s1,
	output tre_pkg::pix_t item_s1
);

	logic accept;

	assign in_stall = valid_s1 && !advance;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

endmodule

[src/tre_run_tracker.sv]
module tre_run_tracker #(
	parameter int MAX_LINE_WIDTH = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [tre_pkg::PixW-1:0]  cfg_data,
	input  tre_pkg::pix_t             item,
	input  logic                      advance,
	output logic                      emit,
	output tre_pkg::run_t             run
);

	localparam int CW = $clog2(MAX_LINE_WIDTH);
	localparam logic [CW-1:0] LastCol = CW'(MAX_LINE_WIDTH - 1);

	logic [tre_pkg::PixW-1:0] thr_q;
	logic [CW-1:0] col_q;
	logic          inside_q;
	logic [CW-1:0] open_q;
	logic          held_v_q;
	logic [CW-1:0] held_start_q;
	logic [CW-1:0] held_stop_q;

	logic [CW-1:0] col_d;
	logic          inside_d;
	logic [CW-1:0] open_d;
	logic          held_v_d;
	logic [CW-1:0] held_start_d;
	logic [CW-1:0] held_stop_d;

	logic          lit;
	logic          last;
	logic [CW-1:0] first_c;
	logic [CW:0]   stop_c;

	always_comb begin
		lit = item.pixel_value > thr_q;
		last = item.line_end || (col_q == LastCol);
		col_d = col_q;
		inside_d = inside_q;
		open_d = open_q;
		held_v_d = held_v_q;
		held_start_d = held_start_q;
		held_stop_d = held_stop_q;
		emit = 1'b0;
		first_c = held_start_q;
		stop_c = {1'b0, held_stop_q};

		priority if (col_q == '0) begin
			held_v_d = 1'b0;
			inside_d = lit;
			open_d = '0;
		end else if (inside_q && !lit) begin
			if ((col_q - open_q) > CW'(1)) begin
				held_v_d = 1'b1;
				held_start_d = open_q;
				held_stop_d = col_q;
			end
			inside_d = 1'b0;
		end else if (!inside_q && lit) begin
			if (held_v_q) begin
				open_d = held_start_q;
				held_v_d = 1'b0;
			end else begin
				open_d = col_q;
			end
			inside_d = 1'b1;
		end else if (!inside_q && !lit && held_v_q && (col_q > held_stop_q)) begin
			emit = 1'b1;
			held_v_d = 1'b0;
		end else begin
		end

		if (last) begin
			if (inside_d) begin
				emit = 1'b1;
				first_c = open_d;
				stop_c = {1'b0, col_q} + (CW + 1)'(1);
			end else if (held_v_d) begin
				emit = 1'b1;
				first_c = held_start_d;
				stop_c = {1'b0, held_stop_d};
			end
			col_d = '0;
			inside_d = 1'b0;
			held_v_d = 1'b0;
		end else begin
			col_d = col_q + CW'(1);
		end

		run.row = item.row_number;
		run.first = tre_pkg::ColW'(first_c);
		run.stop = tre_pkg::StopW'(stop_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= tre_pkg::ThresholdReset;
		end else if (cfg_write) begin
			thr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			inside_q <= 1'b0;
			open_q <= '0;
			held_v_q <= 1'b0;
			held_start_q <= '0;
			held_stop_q <= '0;
		end else if (advance) begin
			col_q <= col_d;
			inside_q <= inside_d;
			open_q <= open_d;
			held_v_q <= held_v_d;
			held_start_q <= held_start_d;
			held_stop_q <= held_stop_d;
		end
	end

endmodule

[src/tre_out_stage.sv]
module tre_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  tre_pkg::run_t run,
	output logic          room,
	output logic          out_valid,
	input  logic          out_stall,
	output tre_pkg::run_t out_run
);

	logic out_valid_q;
	tre_pkg::run_t run_q;

	assign room = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_run = run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_q <= run;
		end
	end

endmodule

[src/thresholded_run_extraction_top.sv]
// A run passes from the input register through the run tracker into the output register.
// Throughput: one pixel item per cycle unless a run waits on a stalled output; each item
// needs one threshold compare and a run tracker register update after the input register.
// Reset: arst_n clears all run state and the valid flags of both stages and sets the threshold to 128.
module thresholded_run_extraction_top #(
	parameter int MAX_LINE_WIDTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [tre_pkg::PixW-1:0]   cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [tre_pkg::PixW-1:0]   pixel_value,
	input  logic [tre_pkg::RowW-1:0]   row_number,
	input  logic                       line_end,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tre_pkg::RowW-1:0]   run_row,
	output logic [tre_pkg::ColW-1:0]   run_first,
	output logic [tre_pkg::StopW-1:0]  run_stop,
	output logic                       burst_last
);

	tre_pkg::pix_t in_item;
	tre_pkg::pix_t item_s1;
	tre_pkg::run_t run;
	tre_pkg::run_t out_run;
	logic          valid_s1;
	logic          emit;
	logic          room;
	logic          advance;

	assign in_item.pixel_value = pixel_value;
	assign in_item.row_number = row_number;
	assign in_item.line_end = line_end;

	assign advance = valid_s1 && (!emit || room);

	tre_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tre_run_tracker #(
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.item      (item_s1),
		.advance   (advance),
		.emit      (emit),
		.run       (run)
	);

	tre_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.run       (run),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_run   (out_run)
	);

	assign run_row = out_run.row;
	assign run_first = out_run.first;
	assign run_stop = out_run.stop;
	assign burst_last = 1'b1;

endmodule
